>>> src/tcpq_pkg.sv
// Shared types and constants of the two-class priority queue.
package tcpq_pkg;

    // Operation codes carried by the input transaction.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes of the result transaction.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Reset value of the urgent threshold register.
    localparam logic signed [15:0] THRESHOLD_RESET = 16'sd1;

    // Contents of one queue cell.
    typedef struct packed {
        logic               valid;
        logic               urgent;
        logic signed [15:0] value;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               push_en;
        logic               pop_en;
        logic               urgent;
        logic signed [15:0] value;
    } cmd_t;

endpackage

>>> src/tcpq_cell.sv
// One cell of the queue chain: holds one entry and shifts toward either neighbor.
module tcpq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  tcpq_pkg::cmd_t  cmd,
    input  tcpq_pkg::entry_t prev_entry,
    input  tcpq_pkg::entry_t next_entry,
    output tcpq_pkg::entry_t entry
);

    logic               valid_reg;
    logic               valid_next;
    logic               urgent_reg;
    logic               urgent_next;
    logic signed [15:0] value_reg;
    logic signed [15:0] value_next;
    logic               take_new;
    logic               take_prev;

    // Insertion decisions made from this cell and its upstream neighbor only.
    // Urgent entries sit in one run at the front, so an urgent push lands in the
    // first cell that is not urgent, and every ordinary entry behind it moves down.
    always_comb
    begin
        if (cmd.urgent)
        begin
            take_new  = prev_entry.valid && prev_entry.urgent && !(valid_reg && urgent_reg);
            take_prev = prev_entry.valid && !prev_entry.urgent;
        end
        else
        begin
            take_new  = prev_entry.valid && !valid_reg;
            take_prev = 1'b0;
        end
    end

    // Next contents: a pop pulls from downstream, a push inserts or pushes down.
    always_comb
    begin
        valid_next  = valid_reg;
        urgent_next = urgent_reg;
        value_next  = value_reg;
        if (cmd.pop_en)
        begin
            valid_next  = next_entry.valid;
            urgent_next = next_entry.urgent;
            value_next  = next_entry.value;
        end
        else if (cmd.push_en && take_new)
        begin
            valid_next  = 1'b1;
            urgent_next = cmd.urgent;
            value_next  = cmd.value;
        end
        else if (cmd.push_en && take_prev)
        begin
            valid_next  = prev_entry.valid;
            urgent_next = prev_entry.urgent;
            value_next  = prev_entry.value;
        end
    end

    // Only the valid flag needs reset; the payload is ignored while invalid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        urgent_reg <= urgent_next;
        value_reg  <= value_next;
    end

    assign entry.valid  = valid_reg;
    assign entry.urgent = urgent_reg;
    assign entry.value  = value_reg;

endmodule

>>> src/two_class_priority_queue_unit.sv
// Top level of the two-class strict priority queue built as a chain of cells.
//
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     operation, value
// result    out        out_valid / out_ready   popped_value, status, occupancy
// config    in         cfg_wr_en               cfg_wr_data (urgent threshold)
//
// Every transaction is applied to all cells at the accepting edge, and its result is
// presented from the output register in the next cycle.
// One transaction per cycle is sustained while results are taken; the output
// register is the only stage, so a stalled result holds off the next transaction.
// Reset clears every cell's valid flag at once; there is no clearing pass.
// The head of the queue is always cell zero, so a pop reads a fixed place.
module two_class_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] popped_value,
    output logic [1:0]         status,
    output logic [7:0]         occupancy,
    input  logic               cfg_wr_en,
    input  logic signed [15:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [15:0] threshold_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] popped_value_reg;
    logic signed [15:0] popped_value_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [CNT_W+7:0]   count_wide;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    tcpq_pkg::cmd_t     cmd;
    tcpq_pkg::entry_t   cells [QUEUE_DEPTH];

    // A new transaction enters when the output register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Command broadcast to the chain; refused operations leave the cells alone.
    assign cmd.push_en = accept && (operation == tcpq_pkg::OP_PUSH) && !is_full;
    assign cmd.pop_en  = accept && (operation == tcpq_pkg::OP_POP) && !is_empty;
    assign cmd.urgent  = (value >= threshold_reg);
    assign cmd.value   = value;

    // The chain of cells; the front sees an urgent guard and the back an empty cell.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        tcpq_pkg::entry_t prev_entry;
        tcpq_pkg::entry_t next_entry;

        if (i == 0)
        begin : g_front
            assign prev_entry.valid  = 1'b1;
            assign prev_entry.urgent = 1'b1;
            assign prev_entry.value  = '0;
        end
        else
        begin : g_inner_prev
            assign prev_entry = cells[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_back
            assign next_entry.valid  = 1'b0;
            assign next_entry.urgent = 1'b0;
            assign next_entry.value  = '0;
        end
        else
        begin : g_inner_next
            assign next_entry = cells[i+1];
        end

        tcpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cells[i])
        );
    end

    // Result of the transaction being accepted.
    always_comb
    begin
        count_next        = count_reg;
        popped_value_next = popped_value_reg;
        status_next       = status_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (accept)
        begin
            out_valid_next    = 1'b1;
            popped_value_next = '0;
            status_next       = tcpq_pkg::STATUS_DONE;
            if (operation == tcpq_pkg::OP_PUSH)
            begin
                if (is_full)
                begin
                    status_next = tcpq_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = tcpq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    popped_value_next = cells[0].value;
                    count_next        = count_reg - CNT_W'(1);
                end
            end
        end
    end

    // Control registers and the threshold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tcpq_pkg::THRESHOLD_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        popped_value_reg <= popped_value_next;
        status_reg       <= status_next;
    end

    // Occupancy is reported modulo 256; the count only changes on acceptance.
    assign count_wide   = {8'd0, count_reg};
    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign occupancy    = count_wide[7:0];

endmodule

>>> src/tcpq_checker.sv
// Port-level checker of the two-class priority queue, bound to the top level.
module tcpq_checker #(
    parameter int QUEUE_DEPTH = 128
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] popped_value,
    input logic [1:0]         status,
    input logic [7:0]         occupancy
);

    localparam logic [7:0] DEPTH_LOW = 8'(QUEUE_DEPTH % 256);

    // A refused transaction never reports a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != tcpq_pkg::STATUS_DONE) |-> popped_value == 16'sd0)
        else $error("refused transaction reported a nonzero value");

    // A pop refused as empty means the queue holds nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tcpq_pkg::STATUS_EMPTY) |-> occupancy == 8'd0)
        else $error("empty refusal with nonzero occupancy");

    // A push refused as full means the queue holds its full depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tcpq_pkg::STATUS_FULL) |-> occupancy == DEPTH_LOW)
        else $error("full refusal with occupancy below depth");

    // The input side only stalls behind a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(status)
            && $stable(occupancy))
        else $error("stalled result changed");

endmodule

bind two_class_priority_queue_unit tcpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tcpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy)
);
